// ----- hdl/avu_pkg.sv -----
`default_nettype none
package avu_pkg;

	localparam int XW   = 32;
	localparam int DTW  = 17;
	localparam int CW   = 31;
	localparam int OFW  = 33;
	localparam int SQ1W = 66;
	localparam int RT1W = 33;
	localparam int QUOW = 32;
	localparam int NVW  = 35;
	localparam int SQ2W = 70;
	localparam int RT2W = 35;

	typedef enum logic {
		REG_SLOWING = 1'b0,
		REG_TOP     = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [2:0][OFW-1:0] d;
		logic [2:0][XW-1:0]  vel;
		logic [DTW-1:0]      dt;
	} pa_t;

	typedef struct packed {
		logic [2:0]         sgn;
		logic [2:0][XW-1:0] vel;
		logic [DTW-1:0]     dt;
	} pb_t;

	typedef struct packed {
		logic [2:0][NVW-1:0] nv;
		logic                clamp;
	} pc_t;

	typedef struct packed {
		logic [2:0]          sgn;
		logic [2:0][NVW-1:0] nv;
		logic                clamp;
	} pd_t;

endpackage
`default_nettype wire

// ----- hdl/avu_sqrt_cell.sv -----
`default_nettype none
module avu_sqrt_cell import avu_pkg::*; #(
	parameter int RW = SQ1W
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [RW-1:0]     rad_i,
	input  wire logic [RW/2+2:0]   rem_i,
	input  wire logic [RW/2-1:0]   root_i,
	output logic      [RW-1:0]     rad_o,
	output logic      [RW/2+2:0]   rem_o,
	output logic      [RW/2-1:0]   root_o
);
	localparam int N   = RW / 2;
	localparam int RMW = N + 3;

	logic [RMW-1:0] acc;
	logic [RMW-1:0] trial;
	logic           ge;

	always_comb begin
		acc   = {rem_i[RMW-3:0], rad_i[RW-1:RW-2]};
		trial = {1'b0, root_i, 2'b01};
		ge    = acc >= trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_o  <= {rad_i[RW-3:0], 2'b00};
			rem_o  <= ge ? acc - trial : acc;
			root_o <= {root_i[N-2:0], ge};
		end
	end
endmodule
`default_nettype wire

// ----- hdl/avu_div_cell.sv -----
`default_nettype none
module avu_div_cell import avu_pkg::*; #(
	parameter int DW = OFW,
	parameter int QW = QUOW
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [DW-1:0] den_i,
	input  wire logic [DW-1:0] r_i,
	input  wire logic [QW-1:0] lq_i,
	output logic      [DW-1:0] den_o,
	output logic      [DW-1:0] r_o,
	output logic      [QW-1:0] lq_o
);
	logic [DW:0] acc;
	logic [DW:0] dif;
	logic        ge;

	always_comb begin
		acc = {r_i, lq_i[QW-1]};
		dif = acc - {1'b0, den_i};
		ge  = acc >= {1'b0, den_i};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_o <= den_i;
			r_o   <= ge ? dif[DW-1:0] : acc[DW-1:0];
			lq_o  <= {lq_i[QW-2:0], ge};
		end
	end
endmodule
`default_nettype wire

// ----- hdl/avu_delay.sv -----
`default_nettype none
module avu_delay import avu_pkg::*; #(
	parameter int W = XW,
	parameter int N = 2
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] din,
	output logic      [W-1:0] dout
);
	logic [W-1:0] sr_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			sr_q[0] <= din;
			for (int k = 1; k < N; k++) begin
				sr_q[k] <= sr_q[k-1];
			end
		end
	end

	assign dout = sr_q[N-1];
endmodule
`default_nettype wire

// ----- hdl/arrive_steering_velocity_update.sv -----
// throughput: one item per cycle while the output is not stalled; fully
// pipelined through two chains of square root cells and two sets of
// divider cell chains, one chain per axis; one bit per cell
// a stalled output holds the whole pipeline and stalls the input
// reset clears all valid bits; slowing_distance and top_speed reset to 1.0
`default_nettype none
module arrive_steering_velocity_update import avu_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic                  cfg_index,
	input  wire logic [CW-1:0]         cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [XW-1:0]         target_x,
	input  wire logic [XW-1:0]         target_y,
	input  wire logic [XW-1:0]         target_z,
	input  wire logic [XW-1:0]         pos_x,
	input  wire logic [XW-1:0]         pos_y,
	input  wire logic [XW-1:0]         pos_z,
	input  wire logic [XW-1:0]         vel_x,
	input  wire logic [XW-1:0]         vel_y,
	input  wire logic [XW-1:0]         vel_z,
	input  wire logic [DTW-1:0]        time_step,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [XW-1:0]              new_vel_x,
	output logic [XW-1:0]              new_vel_y,
	output logic [XW-1:0]              new_vel_z
);
	localparam int VALN = 3 + RT1W + 1 + QUOW + 6 + RT2W + 1 + QUOW;
	localparam int R1W  = RT1W + 3;
	localparam int R2W  = RT2W + 3;

	logic en;
	logic [VALN-1:0] vld_q;
	logic out_valid_q;
	logic [CW-1:0] sd_q;
	logic [CW-1:0] top_q;

	assign en        = !out_valid_q || !out_stall;
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sd_q  <= CW'(65536);
			top_q <= CW'(65536);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SLOWING: sd_q <= cfg_data;
				REG_TOP:     top_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q       <= {vld_q[VALN-2:0], in_valid};
			out_valid_q <= vld_q[VALN-1];
		end
	end

	// offsets and squared distance
	logic [2:0][XW-1:0] tgt_c, pos_c, vin_c;
	assign tgt_c = {target_z, target_y, target_x};
	assign pos_c = {pos_z, pos_y, pos_x};
	assign vin_c = {vel_z, vel_y, vel_x};

	logic [2:0][OFW-1:0]  d_s1, d_s2, d_s3;
	logic [2:0][XW-1:0]   vel_s1, vel_s2, vel_s3;
	logic [DTW-1:0]       dt_s1, dt_s2, dt_s3;
	logic [2:0][SQ1W-1:0] sq_s2;
	logic [SQ1W-1:0]      sum_s3;
	logic [2:0][OFW-1:0]  dmag_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dmag_c[i] = d_s1[i][OFW-1] ? OFW'(0) - d_s1[i] : d_s1[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= {tgt_c[i][XW-1], tgt_c[i]} - {pos_c[i][XW-1], pos_c[i]};
				sq_s2[i] <= SQ1W'(dmag_c[i]) * SQ1W'(dmag_c[i]);
			end
			vel_s1 <= vin_c;
			dt_s1  <= time_step;
			d_s2   <= d_s1;
			vel_s2 <= vel_s1;
			dt_s2  <= dt_s1;
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			d_s3   <= d_s2;
			vel_s3 <= vel_s2;
			dt_s3  <= dt_s2;
		end
	end

	// distance root
	logic [SQ1W-1:0] ra_rad  [RT1W+1];
	logic [R1W-1:0]  ra_rem  [RT1W+1];
	logic [RT1W-1:0] ra_root [RT1W+1];

	assign ra_rad[0]  = sum_s3;
	assign ra_rem[0]  = '0;
	assign ra_root[0] = '0;

	for (genvar k = 0; k < RT1W; k++) begin : g_sqa
		avu_sqrt_cell #(.RW(SQ1W)) u_sq (
			.clk    (clk),
			.en     (en),
			.rad_i  (ra_rad[k]),
			.rem_i  (ra_rem[k]),
			.root_i (ra_root[k]),
			.rad_o  (ra_rad[k+1]),
			.rem_o  (ra_rem[k+1]),
			.root_o (ra_root[k+1])
		);
	end

	pa_t pa_in, pa_out;
	assign pa_in = '{d: d_s3, vel: vel_s3, dt: dt_s3};

	avu_delay #(.W($bits(pa_t)), .N(RT1W)) u_dly_a (
		.clk  (clk),
		.en   (en),
		.din  (pa_in),
		.dout (pa_out)
	);

	// desired velocity numerators and divisor
	logic [OFW-1:0]         den1_c;
	logic [2:0][OFW-1:0]    pmag_c;
	logic [OFW-1:0]         den1_s4;
	logic [2:0][2*XW-1:0]   num1_s4;
	pb_t                    pb_s4;

	always_comb begin
		den1_c = (ra_root[RT1W] < OFW'(sd_q)) ? OFW'(sd_q) : ra_root[RT1W];
		if (den1_c == '0) begin
			den1_c = OFW'(1);
		end
		for (int i = 0; i < 3; i++) begin
			pmag_c[i] = pa_out.d[i][OFW-1] ? OFW'(0) - pa_out.d[i] : pa_out.d[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den1_s4 <= den1_c;
			for (int i = 0; i < 3; i++) begin
				num1_s4[i]   <= (2*XW)'(pmag_c[i]) * (2*XW)'(top_q);
				pb_s4.sgn[i] <= pa_out.d[i][OFW-1];
			end
			pb_s4.vel <= pa_out.vel;
			pb_s4.dt  <= pa_out.dt;
		end
	end

	logic [OFW-1:0]  d1_den [3][QUOW+1];
	logic [OFW-1:0]  d1_r   [3][QUOW+1];
	logic [QUOW-1:0] d1_lq  [3][QUOW+1];

	for (genvar j = 0; j < 3; j++) begin : g_div1
		assign d1_den[j][0] = den1_s4;
		assign d1_r[j][0]   = OFW'(num1_s4[j][2*XW-1:QUOW]);
		assign d1_lq[j][0]  = num1_s4[j][QUOW-1:0];
		for (genvar k = 0; k < QUOW; k++) begin : g_c
			avu_div_cell #(.DW(OFW), .QW(QUOW)) u_dv (
				.clk   (clk),
				.en    (en),
				.den_i (d1_den[j][k]),
				.r_i   (d1_r[j][k]),
				.lq_i  (d1_lq[j][k]),
				.den_o (d1_den[j][k+1]),
				.r_o   (d1_r[j][k+1]),
				.lq_o  (d1_lq[j][k+1])
			);
		end
	end

	pb_t pb_out;

	avu_delay #(.W($bits(pb_t)), .N(QUOW)) u_dly_b (
		.clk  (clk),
		.en   (en),
		.din  (pb_s4),
		.dout (pb_out)
	);

	// velocity step
	logic [2:0][OFW:0]   diff_c;
	logic [2:0][XW:0]    des_c;
	logic [2:0][XW-1:0]  dm_s5;
	logic [2:0]          ds_s5, ds_s6;
	logic [2:0][XW-1:0]  vel_s5, vel_s6;
	logic [DTW-1:0]      dt_s5;
	logic [2:0][XW:0]    stp_s6;
	logic [2:0][XW+DTW-1:0] prod_c;
	logic [2:0][NVW-1:0] nv_s7, nv_s8, nv_s9, nv_s10;
	logic [2:0][NVW-2:0] nmag_c;
	logic [2:0][2*NVW-3:0] nsq_s8;
	logic [2*CW-1:0]     tsq_s8, tsq_s9;
	logic [SQ2W-1:0]     sum2_s9, sum2_s10;
	logic                clamp_s10;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			des_c[i]  = pb_out.sgn[i] ? (XW+1)'(0) - {1'b0, d1_lq[i][QUOW]}
				: {1'b0, d1_lq[i][QUOW]};
			diff_c[i] = {des_c[i][XW], des_c[i]}
				- {{2{pb_out.vel[i][XW-1]}}, pb_out.vel[i]};
			prod_c[i] = (XW+DTW)'(dm_s5[i]) * (XW+DTW)'(dt_s5);
			nmag_c[i] = nv_s7[i][NVW-1] ? (NVW-1)'(NVW'(0) - nv_s7[i])
				: nv_s7[i][NVW-2:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dm_s5[i]  <= diff_c[i][OFW] ? XW'((OFW+1)'(0) - diff_c[i])
					: diff_c[i][XW-1:0];
				ds_s5[i]  <= diff_c[i][OFW];
				stp_s6[i] <= prod_c[i][XW+DTW-1:16];
				nv_s7[i]  <= ds_s6[i]
					? {{3{vel_s6[i][XW-1]}}, vel_s6[i]} - {2'b00, stp_s6[i]}
					: {{3{vel_s6[i][XW-1]}}, vel_s6[i]} + {2'b00, stp_s6[i]};
				nsq_s8[i] <= (2*NVW-2)'(nmag_c[i]) * (2*NVW-2)'(nmag_c[i]);
			end
			vel_s5   <= pb_out.vel;
			dt_s5    <= pb_out.dt;
			ds_s6    <= ds_s5;
			vel_s6   <= vel_s5;
			tsq_s8   <= (2*CW)'(top_q) * (2*CW)'(top_q);
			nv_s8    <= nv_s7;
			sum2_s9  <= SQ2W'(nsq_s8[0]) + SQ2W'(nsq_s8[1]) + SQ2W'(nsq_s8[2]);
			tsq_s9   <= tsq_s8;
			nv_s9    <= nv_s8;
			clamp_s10 <= sum2_s9 > SQ2W'(tsq_s9);
			sum2_s10 <= sum2_s9;
			nv_s10   <= nv_s9;
		end
	end

	// speed root
	logic [SQ2W-1:0] rb_rad  [RT2W+1];
	logic [R2W-1:0]  rb_rem  [RT2W+1];
	logic [RT2W-1:0] rb_root [RT2W+1];

	assign rb_rad[0]  = sum2_s10;
	assign rb_rem[0]  = '0;
	assign rb_root[0] = '0;

	for (genvar k = 0; k < RT2W; k++) begin : g_sqb
		avu_sqrt_cell #(.RW(SQ2W)) u_sq (
			.clk    (clk),
			.en     (en),
			.rad_i  (rb_rad[k]),
			.rem_i  (rb_rem[k]),
			.root_i (rb_root[k]),
			.rad_o  (rb_rad[k+1]),
			.rem_o  (rb_rem[k+1]),
			.root_o (rb_root[k+1])
		);
	end

	pc_t pc_in, pc_out;
	assign pc_in = '{nv: nv_s10, clamp: clamp_s10};

	avu_delay #(.W($bits(pc_t)), .N(RT2W)) u_dly_c (
		.clk  (clk),
		.en   (en),
		.din  (pc_in),
		.dout (pc_out)
	);

	// rescale to top speed
	localparam int N2W = NVW - 1 + CW;

	logic [2:0][NVW-2:0] cmag_c;
	logic [RT2W-1:0]     den2_s11;
	logic [2:0][N2W-1:0] num2_s11;
	pd_t                 pd_s11;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cmag_c[i] = pc_out.nv[i][NVW-1] ? (NVW-1)'(NVW'(0) - pc_out.nv[i])
				: pc_out.nv[i][NVW-2:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den2_s11 <= (rb_root[RT2W] == '0) ? RT2W'(1) : rb_root[RT2W];
			for (int i = 0; i < 3; i++) begin
				num2_s11[i]   <= N2W'(cmag_c[i]) * N2W'(top_q);
				pd_s11.sgn[i] <= pc_out.nv[i][NVW-1];
			end
			pd_s11.nv    <= pc_out.nv;
			pd_s11.clamp <= pc_out.clamp;
		end
	end

	logic [RT2W-1:0] d2_den [3][QUOW+1];
	logic [RT2W-1:0] d2_r   [3][QUOW+1];
	logic [QUOW-1:0] d2_lq  [3][QUOW+1];

	for (genvar j = 0; j < 3; j++) begin : g_div2
		assign d2_den[j][0] = den2_s11;
		assign d2_r[j][0]   = RT2W'(num2_s11[j][N2W-1:QUOW]);
		assign d2_lq[j][0]  = num2_s11[j][QUOW-1:0];
		for (genvar k = 0; k < QUOW; k++) begin : g_c
			avu_div_cell #(.DW(RT2W), .QW(QUOW)) u_dv (
				.clk   (clk),
				.en    (en),
				.den_i (d2_den[j][k]),
				.r_i   (d2_r[j][k]),
				.lq_i  (d2_lq[j][k]),
				.den_o (d2_den[j][k+1]),
				.r_o   (d2_r[j][k+1]),
				.lq_o  (d2_lq[j][k+1])
			);
		end
	end

	pd_t pd_out;

	avu_delay #(.W($bits(pd_t)), .N(QUOW)) u_dly_d (
		.clk  (clk),
		.en   (en),
		.din  (pd_s11),
		.dout (pd_out)
	);

	// result select and saturation
	logic [2:0][XW-1:0] res_c;
	logic [2:0][XW-1:0] res_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (pd_out.clamp) begin
				res_c[i] = pd_out.sgn[i] ? XW'(0) - d2_lq[i][QUOW] : d2_lq[i][QUOW];
			end else if ($signed(pd_out.nv[i]) > $signed(NVW'(32'h7fff_ffff))) begin
				res_c[i] = 32'h7fff_ffff;
			end else if ($signed(pd_out.nv[i]) < $signed({{(NVW-XW){1'b1}}, 32'h8000_0000}))
			begin
				res_c[i] = 32'h8000_0000;
			end else begin
				res_c[i] = pd_out.nv[i][XW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_c;
		end
	end

	assign new_vel_x = res_q[0];
	assign new_vel_y = res_q[1];
	assign new_vel_z = res_q[2];
endmodule
`default_nettype wire

// ----- tb/tb_arrive_steering_velocity_update.sv -----
`default_nettype none
module tb_arrive_steering_velocity_update;
	import avu_pkg::*;

	typedef struct {
		logic [2:0][XW-1:0] tgt;
		logic [2:0][XW-1:0] pos;
		logic [2:0][XW-1:0] vel;
		logic [DTW-1:0]     dt;
	} agent_t;

	typedef logic [2:0][XW-1:0] velocity_t;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 300;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic               cfg_index;
	logic [CW-1:0]      cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [XW-1:0]      target_x, target_y, target_z;
	logic [XW-1:0]      pos_x, pos_y, pos_z;
	logic [XW-1:0]      vel_x, vel_y, vel_z;
	logic [DTW-1:0]     time_step;
	logic               out_valid;
	logic               out_stall;
	logic [XW-1:0]      new_vel_x, new_vel_y, new_vel_z;

	logic [63:0]        slow_dist_q;
	logic [63:0]        top_speed_q;
	velocity_t          expected_vel_q[$];
	int                 errors;
	int                 snd_pct;
	int                 rcv_pct;
	int                 idle_count;

	arrive_steering_velocity_update u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.target_x(target_x), .target_y(target_y), .target_z(target_z),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
		.time_step(time_step),
		.out_valid(out_valid), .out_stall(out_stall),
		.new_vel_x(new_vel_x), .new_vel_y(new_vel_y), .new_vel_z(new_vel_z)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [63:0] floor_root(input logic [127:0] n);
		logic [127:0] r, rem, trial;
		r = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = (rem << 2) | ((n >> (2 * i)) & 128'd3);
			trial = (r << 2) | 128'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				r = (r << 1) | 128'd1;
			end else begin
				r = r << 1;
			end
		end
		return r[63:0];
	endfunction

	function automatic logic [63:0] magnitude(input longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint scale_toward_zero(input longint v, input logic [63:0] num,
			input logic [63:0] den);
		logic [127:0] m;
		m = {64'd0, magnitude(v)} * {64'd0, num} / {64'd0, den};
		return v < 0 ? -longint'(m[63:0]) : longint'(m[63:0]);
	endfunction

	function automatic velocity_t steer_velocity(input agent_t a);
		longint       d[3], des[3], nv[3], diff;
		logic [127:0] sum;
		logic [63:0]  span, step, len;
		velocity_t    res;
		sum = '0;
		for (int i = 0; i < 3; i++) begin
			d[i] = longint'($signed(a.tgt[i])) - longint'($signed(a.pos[i]));
			sum = sum + {64'd0, magnitude(d[i])} * {64'd0, magnitude(d[i])};
		end
		span = floor_root(sum);
		for (int i = 0; i < 3; i++) begin
			if (span == 0)
				des[i] = 0;
			else if (span < slow_dist_q)
				des[i] = scale_toward_zero(d[i], top_speed_q, slow_dist_q);
			else
				des[i] = scale_toward_zero(d[i], top_speed_q, span);
		end
		sum = '0;
		for (int i = 0; i < 3; i++) begin
			diff = des[i] - longint'($signed(a.vel[i]));
			step = (magnitude(diff) * {47'd0, a.dt}) >> 16;
			nv[i] = diff < 0 ? longint'($signed(a.vel[i])) - longint'(step)
				: longint'($signed(a.vel[i])) + longint'(step);
			sum = sum + {64'd0, magnitude(nv[i])} * {64'd0, magnitude(nv[i])};
		end
		if (sum > {64'd0, top_speed_q * top_speed_q}) begin
			len = floor_root(sum);
			if (len != 0)
				for (int i = 0; i < 3; i++)
					nv[i] = scale_toward_zero(nv[i], top_speed_q, len);
		end
		for (int i = 0; i < 3; i++) begin
			if (nv[i] > 64'sd2147483647)
				nv[i] = 64'sd2147483647;
			if (nv[i] < -64'sd2147483648)
				nv[i] = -64'sd2147483648;
			res[i] = nv[i][31:0];
		end
		return res;
	endfunction

	task automatic report(input string what, input logic [XW-1:0] got, input logic [XW-1:0] exp);
		$display("mismatch %s: got %h expected %h", what, got, exp);
		errors++;
	endtask

	// result checking
	always @(posedge clk) begin
		velocity_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_vel_q.size() == 0) begin
				report("unexpected result", new_vel_x, '0);
			end else begin
				e = expected_vel_q.pop_front();
				if (new_vel_x !== e[0]) report("new_vel_x", new_vel_x, e[0]);
				if (new_vel_y !== e[1]) report("new_vel_y", new_vel_y, e[1]);
				if (new_vel_z !== e[2]) report("new_vel_z", new_vel_z, e[2]);
			end
		end
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(0, 99) < rcv_pct);

	// watchdog on transfers of any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_item(input agent_t a);
		@(negedge clk);
		while ($urandom_range(0, 99) < snd_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		{target_x, target_y, target_z} <= {a.tgt[0], a.tgt[1], a.tgt[2]};
		{pos_x, pos_y, pos_z} <= {a.pos[0], a.pos[1], a.pos[2]};
		{vel_x, vel_y, vel_z} <= {a.vel[0], a.vel[1], a.vel[2]};
		time_step <= a.dt;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		expected_vel_q.insert(expected_vel_q.size(), steer_velocity(a));
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_vel_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CW-1:0] value);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_SLOWING)
			slow_dist_q = {33'd0, value};
		else
			top_speed_q = {33'd0, value};
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic agent_t make_agent(input logic [31:0] t, input logic [31:0] p,
			input logic [31:0] v, input logic [DTW-1:0] dt);
		agent_t a;
		for (int i = 0; i < 3; i++) begin
			a.tgt[i] = t;
			a.pos[i] = p;
			a.vel[i] = v;
		end
		a.dt = dt;
		return a;
	endfunction

	function automatic agent_t random_agent();
		agent_t a;
		bit     near;
		near = ($urandom_range(0, 3) != 0);
		for (int i = 0; i < 3; i++) begin
			a.pos[i] = $urandom;
			a.tgt[i] = near ? a.pos[i] + ($signed($urandom) >>> $urandom_range(6, 31))
				: $urandom;
			a.vel[i] = $signed($urandom) >>> $urandom_range(0, 31);
		end
		a.dt = ($urandom_range(0, 9) == 0) ? DTW'($urandom) : DTW'($urandom_range(0, 65536));
		return a;
	endfunction

	task automatic test_directed();
		agent_t a;
		send_item(make_agent(32'h0001_0000, 32'h0001_0000, 32'h0000_8000, 17'd65536));
		send_item(make_agent(32'h7fff_ffff, 32'h8000_0000, 32'h0, 17'd65536));
		send_item(make_agent(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 17'd65536));
		send_item(make_agent(32'h0000_4000, 32'h0, 32'h8000_0000, 17'h1ffff));
		send_item(make_agent(32'h0000_0001, 32'h0, 32'hffff_ffff, 17'd0));
		send_item(make_agent(32'h0000_2000, 32'hffff_e000, 32'h0, 17'd32768));
		a = make_agent(32'h0, 32'h0, 32'h0, 17'd65536);
		a.tgt[0] = 32'h0100_0000;
		a.vel[1] = 32'h0002_0000;
		send_item(a);
		write_reg(REG_SLOWING, '0);
		send_item(make_agent(32'h0000_0100, 32'h0, 32'h0, 17'd65536));
		send_item(make_agent(32'h5, 32'h5, 32'h1234_5678, 17'd1));
		write_reg(REG_TOP, '0);
		send_item(make_agent(32'h0003_0000, 32'h0, 32'h0001_0000, 17'd65536));
		send_item(make_agent(32'hffff_0000, 32'h0, 32'h8000_0000, 17'h1ffff));
		write_reg(REG_TOP, '1);
		write_reg(REG_SLOWING, '1);
		send_item(make_agent(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 17'h1ffff));
		send_item(make_agent(32'h0100_0000, 32'h0, 32'h8000_0000, 17'd65536));
		send_item(make_agent(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 17'd65536));
		write_reg(REG_SLOWING, 31'd1);
		send_item(make_agent(32'h0000_0002, 32'h0, 32'h0, 17'd65536));
		send_item(make_agent(32'h8000_0000, 32'h7fff_ffff, 32'h0, 17'd40000));
	endtask

	function automatic logic [CW-1:0] pick_setting();
		case ($urandom_range(0, 5))
			0: return 31'd1;
			1: return '1;
			2: return 31'd65536;
			3: return CW'($urandom_range(1, 64)) << 16;
			4: return CW'($urandom) >> $urandom_range(0, 30);
			default: return CW'($urandom);
		endcase
	endfunction

	task automatic test_random(input int per_setting);
		write_reg(REG_SLOWING, pick_setting());
		write_reg(REG_TOP, ($urandom_range(0, 7) == 0) ? '0 : pick_setting());
		for (int n = 0; n < per_setting; n++) begin
			send_item(random_agent());
			if (n == per_setting / 2)
				drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_SLOWING;
		cfg_data = '0;
		in_valid = 1'b0;
		{target_x, target_y, target_z, pos_x, pos_y, pos_z} = '0;
		{vel_x, vel_y, vel_z} = '0;
		time_step = '0;
		out_stall = 1'b0;
		errors = 0;
		idle_count = 0;
		slow_dist_q = 64'd65536;
		top_speed_q = 64'd65536;
		snd_pct = 6;
		rcv_pct = 69;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		for (int m = 0; m < 3; m++) begin
			snd_pct = (m == 0) ? 6 : (m == 1) ? 69 : 0;
			rcv_pct = (m == 0) ? 69 : (m == 1) ? 6 : 0;
			for (int k = 0; k < 4; k++)
				test_random(52);
		end
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_vel_q.size() != 0) begin
			$display("missing %0d results", expected_vel_q.size());
			errors++;
		end
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire

// ----- filelist.f -----
hdl/avu_pkg.sv
hdl/avu_sqrt_cell.sv
hdl/avu_div_cell.sv
hdl/avu_delay.sv
hdl/arrive_steering_velocity_update.sv
tb/tb_arrive_steering_velocity_update.sv
